@@ src/votc_pkg.sv @@
`default_nettype none

package votc_pkg;

    // Default build parameters.
    localparam int SCREEN_LIMIT_DEF = 320;
    localparam int CLIP_DEPTH_DEF   = 32;

    // Field widths fixed by the command format.
    localparam int CORNER_W = 5;
    localparam int COORD_W  = 16;
    localparam int COEF_W   = 32;
    localparam int SCREEN_W = 32;
    localparam int CODE_W   = 4;
    localparam int PROD_W   = COEF_W + COORD_W;
    localparam int NUM_CORNERS = 6;

    // Configuration register indexes.
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_YX  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ZX  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_XY  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEF_YY  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ZY  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd65536;

    // Command codes.
    localparam logic [2:0] REQ_VERTEX  = 3'd0;
    localparam logic [2:0] REQ_ONE_TRI = 3'd1;
    localparam logic [2:0] REQ_TWO_TRI = 3'd2;
    localparam logic [2:0] REQ_END     = 3'd3;

    // Result kinds.
    localparam logic [1:0] KIND_VERTEX  = 2'd0;
    localparam logic [1:0] KIND_ONE_TRI = 2'd1;
    localparam logic [1:0] KIND_TWO_TRI = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // Outcode bits.
    localparam int CODE_LEFT   = 0;
    localparam int CODE_RIGHT  = 1;
    localparam int CODE_TOP    = 2;
    localparam int CODE_BOTTOM = 3;

    typedef struct packed {
        logic [2:0]                req_type;
        logic                      block_start;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [CORNER_W-1:0]       tri_a0;
        logic [CORNER_W-1:0]       tri_a1;
        logic [CORNER_W-1:0]       tri_a2;
        logic [CORNER_W-1:0]       tri_b0;
        logic [CORNER_W-1:0]       tri_b1;
        logic [CORNER_W-1:0]       tri_b2;
    } t_cmd;

    typedef struct packed {
        logic [1:0]                 out_kind;
        logic signed [SCREEN_W-1:0] screen_x;
        logic signed [SCREEN_W-1:0] screen_y;
        logic [CODE_W-1:0]          outcode;
        logic [CORNER_W-1:0]        out_a0;
        logic [CORNER_W-1:0]        out_a1;
        logic [CORNER_W-1:0]        out_a2;
        logic [CORNER_W-1:0]        out_b0;
        logic [CORNER_W-1:0]        out_b1;
        logic [CORNER_W-1:0]        out_b2;
    } t_res;

endpackage

`default_nettype wire

@@ src/vertex_outcode_triangle_cull.sv @@
// Vertex transform, outcode tagging and trivial-reject triangle culling.
//
// Commands arrive on i_cmd with i_valid and are taken at an edge where
// o_stall is low. Results leave on o_res with o_valid and are taken at an
// edge where i_stall is low. Configuration words are written through
// i_cfg_valid / i_cfg_index / i_cfg_data; o_cfg_ready is always high, and
// writes are expected only while the pipeline is empty.
//
// The datapath is three registers deep: input register, product register
// (six 32x16 multipliers) and result register. A command passes through
// these three registers in turn before its result appears on o_res, and one
// command is taken every cycle while o_stall is low. The clip store is kept
// in three copies of a two-read memory so that all six triangle corners are
// looked up at the same edge; a write from the vertex just ahead is
// forwarded. Commands that produce nothing still take one slot each.
//
// Reset clears the pipeline, the clip write position, the valid bits of the
// clip store and loads the identity transform. When the receiver stalls, the
// result register holds, and the input keeps being taken until the product
// and input registers are also full.

`default_nettype none

module vertex_outcode_triangle_cull #(
    parameter int SCREEN_LIMIT = votc_pkg::SCREEN_LIMIT_DEF,
    parameter int CLIP_DEPTH   = votc_pkg::CLIP_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire votc_pkg::t_cmd                i_cmd,
    output logic                               o_valid,
    input  wire                                i_stall,
    output votc_pkg::t_res                     o_res,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [votc_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  wire [votc_pkg::COEF_W-1:0]         i_cfg_data
);

    localparam int AW     = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
    localparam int PW     = $clog2(CLIP_DEPTH + 1);
    localparam int SUM_W  = votc_pkg::PROD_W + 2;
    localparam int BANKS  = votc_pkg::NUM_CORNERS / 2;
    localparam int CW     = votc_pkg::CORNER_W;
    localparam int SW     = votc_pkg::SCREEN_W;
    localparam logic signed [SW-1:0] LimitQ = SW'(SCREEN_LIMIT * 65536);

    // Saturate the exact sum to the signed screen range.
    function automatic logic signed [SW-1:0] sat_screen(input logic signed [SUM_W-1:0] s);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &s[SUM_W-1:SW-1];
        hi_zeros = ~|s[SUM_W-1:SW-1];
        if (hi_ones || hi_zeros) begin
            return s[SW-1:0];
        end else if (s[SUM_W-1]) begin
            return {1'b1, {(SW-1){1'b0}}};
        end else begin
            return {1'b0, {(SW-1){1'b1}}};
        end
    endfunction

    // Configuration registers.
    logic signed [votc_pkg::COEF_W-1:0] r_cfg [votc_pkg::NUM_REGS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < votc_pkg::NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
            r_cfg[votc_pkg::REG_COEF_XX] <= votc_pkg::COEF_ONE;
            r_cfg[votc_pkg::REG_COEF_YY] <= votc_pkg::COEF_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Pipeline control.
    logic r_v1, r_v2, r_v3;
    logic en1, en2, acc, produce;

    assign en2     = r_v2 && (!produce || !r_v3 || !i_stall);
    assign en1     = r_v1 && (!r_v2 || en2);
    assign o_stall = r_v1 && r_v2 && !en2;
    assign acc     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (acc) begin
                r_v1 <= 1'b1;
            end else if (en1) begin
                r_v1 <= 1'b0;
            end
            if (en1) begin
                r_v2 <= 1'b1;
            end else if (en2) begin
                r_v2 <= 1'b0;
            end
            if (en2 && produce) begin
                r_v3 <= 1'b1;
            end else if (!i_stall) begin
                r_v3 <= 1'b0;
            end
        end
    end

    // Input register.
    votc_pkg::t_cmd r_s1;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= i_cmd;
        end
    end

    // Corner lists of the input and product stages.
    votc_pkg::t_cmd r_s2;
    logic [CW-1:0] s1_corner [votc_pkg::NUM_CORNERS];
    logic [CW-1:0] s2_corner [votc_pkg::NUM_CORNERS];

    always_comb begin
        s1_corner[0] = r_s1.tri_a0;
        s1_corner[1] = r_s1.tri_a1;
        s1_corner[2] = r_s1.tri_a2;
        s1_corner[3] = r_s1.tri_b0;
        s1_corner[4] = r_s1.tri_b1;
        s1_corner[5] = r_s1.tri_b2;
        s2_corner[0] = r_s2.tri_a0;
        s2_corner[1] = r_s2.tri_a1;
        s2_corner[2] = r_s2.tri_a2;
        s2_corner[3] = r_s2.tri_b0;
        s2_corner[4] = r_s2.tri_b1;
        s2_corner[5] = r_s2.tri_b2;
    end

    // Product register: six multiplies of a coefficient by a coordinate.
    logic signed [votc_pkg::PROD_W-1:0] r_p [votc_pkg::NUM_CORNERS];

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s2 <= r_s1;
            r_p[0] <= r_cfg[votc_pkg::REG_COEF_XX] * $signed(r_s1.pos_x);
            r_p[1] <= r_cfg[votc_pkg::REG_COEF_YX] * $signed(r_s1.pos_y);
            r_p[2] <= r_cfg[votc_pkg::REG_COEF_ZX] * $signed(r_s1.pos_z);
            r_p[3] <= r_cfg[votc_pkg::REG_COEF_XY] * $signed(r_s1.pos_x);
            r_p[4] <= r_cfg[votc_pkg::REG_COEF_YY] * $signed(r_s1.pos_y);
            r_p[5] <= r_cfg[votc_pkg::REG_COEF_ZY] * $signed(r_s1.pos_z);
        end
    end

    // Clip store: three identical banks, two reads each, with valid bits.
    logic [votc_pkg::CODE_W-1:0] r_mem [BANKS][CLIP_DEPTH];
    logic                        r_vld [CLIP_DEPTH];
    logic [votc_pkg::CODE_W-1:0] r_rd  [votc_pkg::NUM_CORNERS];
    logic [PW-1:0]               r_wpos;
    logic [PW-1:0]               wpos_base;
    logic                        wr_en;
    logic                        wr_room;
    logic [votc_pkg::CODE_W-1:0] code;

    assign wpos_base = r_s2.block_start ? '0 : r_wpos;
    assign wr_room   = wpos_base < PW'(CLIP_DEPTH);
    assign wr_en     = en2 && (r_s2.req_type == votc_pkg::REQ_VERTEX) && wr_room;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int b = 0; b < BANKS; b++) begin
                r_mem[b][wpos_base[AW-1:0]] <= code;
            end
        end
        if (en1) begin
            for (int k = 0; k < votc_pkg::NUM_CORNERS; k++) begin
                if (({1'b0, s1_corner[k]} < (CW + 1)'(CLIP_DEPTH))
                        && r_vld[s1_corner[k][AW-1:0]]) begin
                    r_rd[k] <= r_mem[k / 2][s1_corner[k][AW-1:0]];
                end else begin
                    r_rd[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < CLIP_DEPTH; e++) begin
                r_vld[e] <= 1'b0;
            end
            r_wpos <= '0;
        end else if (en2 && (r_s2.req_type == votc_pkg::REQ_VERTEX)) begin
            if (wr_room) begin
                r_vld[wpos_base[AW-1:0]] <= 1'b1;
                r_wpos <= wpos_base + PW'(1);
            end else begin
                r_wpos <= PW'(CLIP_DEPTH);
            end
        end
    end

    // Forwarding of a store write made at the same edge as the corner reads.
    logic                        r_fwd_v;
    logic [CW-1:0]               r_fwd_addr;
    logic [votc_pkg::CODE_W-1:0] r_fwd_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (en1) begin
            r_fwd_v <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_fwd_addr <= CW'(wpos_base);
            r_fwd_code <= code;
        end
    end

    // Screen position, outcode and triangle culling.
    logic signed [SUM_W-1:0]       sum_x, sum_y;
    logic signed [SW-1:0]          sx, sy;
    logic [votc_pkg::CODE_W-1:0]   cc [votc_pkg::NUM_CORNERS];
    logic                          a_out, b_out;
    votc_pkg::t_res                n_res;

    always_comb begin
        sum_x = SUM_W'(r_p[0]) + SUM_W'(r_p[1]) + SUM_W'(r_p[2])
              + SUM_W'(r_cfg[votc_pkg::REG_OFFSET_X]);
        sum_y = SUM_W'(r_p[3]) + SUM_W'(r_p[4]) + SUM_W'(r_p[5])
              + SUM_W'(r_cfg[votc_pkg::REG_OFFSET_Y]);
        sx = sat_screen(sum_x);
        sy = sat_screen(sum_y);

        code = '0;
        if (sx < 0) begin
            code[votc_pkg::CODE_LEFT] = 1'b1;
        end else if (sx >= LimitQ) begin
            code[votc_pkg::CODE_RIGHT] = 1'b1;
        end
        if (sy < 0) begin
            code[votc_pkg::CODE_TOP] = 1'b1;
        end else if (sy >= LimitQ) begin
            code[votc_pkg::CODE_BOTTOM] = 1'b1;
        end

        for (int k = 0; k < votc_pkg::NUM_CORNERS; k++) begin
            cc[k] = (r_fwd_v && (r_fwd_addr == s2_corner[k])) ? r_fwd_code : r_rd[k];
        end
        a_out = |(cc[0] & cc[1] & cc[2]);
        b_out = |(cc[3] & cc[4] & cc[5]);

        n_res   = '0;
        produce = 1'b0;
        case (r_s2.req_type)
            votc_pkg::REQ_VERTEX: begin
                produce        = 1'b1;
                n_res.out_kind = votc_pkg::KIND_VERTEX;
                n_res.screen_x = sx;
                n_res.screen_y = sy;
                n_res.outcode  = code;
            end
            votc_pkg::REQ_ONE_TRI: begin
                produce        = !a_out;
                n_res.out_kind = votc_pkg::KIND_ONE_TRI;
                n_res.out_a0   = r_s2.tri_a0;
                n_res.out_a1   = r_s2.tri_a1;
                n_res.out_a2   = r_s2.tri_a2;
            end
            votc_pkg::REQ_TWO_TRI: begin
                produce = !(a_out && b_out);
                if (a_out) begin
                    n_res.out_kind = votc_pkg::KIND_ONE_TRI;
                    n_res.out_a0   = r_s2.tri_b0;
                    n_res.out_a1   = r_s2.tri_b1;
                    n_res.out_a2   = r_s2.tri_b2;
                end else begin
                    n_res.out_a0 = r_s2.tri_a0;
                    n_res.out_a1 = r_s2.tri_a1;
                    n_res.out_a2 = r_s2.tri_a2;
                    if (b_out) begin
                        n_res.out_kind = votc_pkg::KIND_ONE_TRI;
                    end else begin
                        n_res.out_kind = votc_pkg::KIND_TWO_TRI;
                        n_res.out_b0   = r_s2.tri_b0;
                        n_res.out_b1   = r_s2.tri_b1;
                        n_res.out_b2   = r_s2.tri_b2;
                    end
                end
            end
            votc_pkg::REQ_END: begin
                produce        = 1'b1;
                n_res.out_kind = votc_pkg::KIND_END;
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    // Result register.
    votc_pkg::t_res r_res;

    always_ff @(posedge i_clk) begin
        if (en2 && produce) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;

    // The write position never runs past the end of the store.
    a_wpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= PW'(CLIP_DEPTH))
        else $error("clip write position beyond store depth");

    // A new result only comes from an item that sat in the product stage.
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_v2))
        else $error("result appeared without a source item");

    // A vertex's left bit agrees with the sign of its screen x.
    a_left_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.out_kind == votc_pkg::KIND_VERTEX))
            |-> (o_res.outcode[votc_pkg::CODE_LEFT] == o_res.screen_x[SW-1]))
        else $error("vertex outcode disagrees with screen x");

endmodule

`default_nettype wire
